// ----- hdl/midi_input_parser_top_assert.svh -----
// Assertion macros for the MIDI input parser checker.
// No dependencies; included by the checker file only.
`ifndef MIDI_INPUT_PARSER_TOP_ASSERT_SVH
`define MIDI_INPUT_PARSER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define MIP_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mip_pkg.sv -----
// Shared types, codes and helpers for the MIDI input parser.
// No dependencies; used by the front, queue, back, top, checker and testbench.
package mip_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // result kinds
  typedef enum logic [2:0] {
    KIND_RT   = 3'd0,
    KIND_RAW  = 3'd1,
    KIND_NOTE = 3'd2,
    KIND_CTRL = 3'd3,
    KIND_PROG = 3'd4,
    KIND_PRES = 3'd5,
    KIND_BEND = 3'd6
  } kind_t;

  // upper nibble of a status byte
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY     = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_PRES     = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // one queued job: a realtime byte or a completed message
  typedef struct packed {
    logic       is_rt;
    logic [7:0] status;   // realtime byte or message status
    logic [6:0] d0;       // first data byte
    logic [6:0] d1;       // second data byte
    logic [1:0] ndata;    // data bytes in the message, 1 or 2
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // message length in bytes, status included
  function automatic logic [1:0] msg_len(input logic [7:0] status);
    logic [1:0] len;
    case (status[7:4])
      ST_NOTE_OFF, ST_NOTE_ON, ST_POLY, ST_CTRL, ST_BEND: len = 2'd3;
      ST_PROG, ST_PRES:                                   len = 2'd2;
      default:                                            len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/mip_ifs.sv -----
// Channel interfaces of the MIDI input parser: input bytes, results, config.
// No dependencies.
interface midi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface midi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [13:0] main_value;
  logic [6:0]  aux_value;
  logic [3:0]  channel;
  logic        last_of_run;
  modport source (output valid, output event_kind, output main_value, output aux_value,
                  output channel, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input main_value, input aux_value,
                  input channel, input last_of_run, output ready);
endinterface

interface midi_cfg_if;
  logic valid;
  logic ready;
  logic input_enable;
  modport source (output valid, output input_enable, input ready);
  modport sink   (input valid, input input_enable, output ready);
endinterface

// ----- hdl/mip_front.sv -----
// Front end: takes MIDI bytes, tracks running status and collects messages.
// Depends on mip_pkg and the channel interfaces; feeds mip_queue.
module mip_front (
  input  logic            clk,
  input  logic            rst_n,
  midi_in_if.sink         in_ch,
  midi_cfg_if.sink        cfg_ch,
  input  mip_pkg::q_stat_t q_stat,
  output logic            push,
  output mip_pkg::job_t   push_job
);

  logic       en_r;
  logic [7:0] cur_r, cur_nxt;
  logic [7:0] run_r, run_nxt;
  logic [1:0] bc_r, bc_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [6:0] ds0_r, ds1_r;

  logic       acc, is_rt, is_st, is_data;
  logic [7:0] cur_eff;
  logic [1:0] bc_eff, exp_eff, bc_inc;
  logic       have_st, done, wr0, wr1;

  assign in_ch.ready  = !q_stat.full;
  assign cfg_ch.ready = 1'b1;

  assign acc     = in_ch.valid && in_ch.ready && en_r;
  assign is_rt   = &in_ch.midi_byte[7:3];
  assign is_st   = in_ch.midi_byte[7] && !is_rt;
  assign is_data = !in_ch.midi_byte[7];

  // effective message state for a data byte, restarting from running status
  always_comb begin
    cur_eff = cur_r;
    exp_eff = exp_r;
    bc_eff  = bc_r;
    have_st = 1'b1;
    if (cur_r == 8'h00) begin
      if (run_r == 8'h00) begin
        have_st = 1'b0;
      end else begin
        cur_eff = run_r;
        exp_eff = mip_pkg::msg_len(run_r);
        bc_eff  = 2'd1;
      end
    end
    if (bc_eff == 2'd0) begin
      bc_eff = 2'd1;
    end
    bc_inc = (bc_eff != 2'd3) ? bc_eff + 2'd1 : bc_eff;
    done   = (bc_inc >= exp_eff);
  end

  assign wr0 = acc && is_data && have_st && (bc_eff == 2'd1);
  assign wr1 = acc && is_data && have_st && (bc_eff == 2'd2);

  // parse state update
  always_comb begin
    cur_nxt = cur_r;
    run_nxt = run_r;
    bc_nxt  = bc_r;
    exp_nxt = exp_r;
    if (acc && is_st) begin
      cur_nxt = in_ch.midi_byte;
      run_nxt = in_ch.midi_byte;
      bc_nxt  = 2'd1;
      exp_nxt = mip_pkg::msg_len(in_ch.midi_byte);
    end else if (acc && is_data && have_st) begin
      cur_nxt = cur_eff;
      exp_nxt = exp_eff;
      if (!done) begin
        bc_nxt = bc_inc;
      end else if (cur_eff[7:4] == mip_pkg::ST_SYSTEM) begin
        cur_nxt = 8'h00;
        run_nxt = 8'h00;
        bc_nxt  = 2'd0;
        exp_nxt = 2'd0;
      end else begin
        bc_nxt = 2'd1;
      end
    end
  end

  // job toward the back end; data written this cycle is bypassed
  always_comb begin
    push_job.is_rt  = is_rt;
    push_job.status = is_rt ? in_ch.midi_byte : cur_eff;
    push_job.d0     = (bc_eff == 2'd1) ? in_ch.midi_byte[6:0] : ds0_r;
    push_job.d1     = (bc_eff == 2'd2) ? in_ch.midi_byte[6:0] : ds1_r;
    push_job.ndata  = bc_inc - 2'd1;
  end

  assign push = acc && (is_rt || (is_data && have_st && done));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b1;
      cur_r <= 8'h00;
      run_r <= 8'h00;
      bc_r  <= 2'd0;
      exp_r <= 2'd0;
    end else begin
      if (cfg_ch.valid) begin
        en_r <= cfg_ch.input_enable;
      end
      cur_r <= cur_nxt;
      run_r <= run_nxt;
      bc_r  <= bc_nxt;
      exp_r <= exp_nxt;
    end
  end

  // data store, no reset
  always_ff @(posedge clk) begin
    if (wr0) begin
      ds0_r <= in_ch.midi_byte[6:0];
    end
    if (wr1) begin
      ds1_r <= in_ch.midi_byte[6:0];
    end
  end

endmodule

// ----- hdl/mip_queue.sv -----
// Short job queue between the front and back ends of the MIDI parser.
// Depends on mip_pkg.
module mip_queue #(
  parameter int DEPTH = mip_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mip_pkg::job_t    push_job,
  input  logic             pop,
  output mip_pkg::job_t    head,
  output mip_pkg::q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  mip_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = slot_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

// ----- hdl/mip_back.sv -----
// Back end: expands each queued job into realtime, raw-byte and decoded results.
// Depends on mip_pkg and the result interface; drains mip_queue.
module mip_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mip_pkg::job_t    head,
  input  mip_pkg::q_stat_t q_stat,
  output logic             pop,
  midi_out_if.source       out_ch
);

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [13:0] main_r;
  logic [6:0]  aux_r;
  logic [3:0]  chan_r;
  logic        last_r;

  logic [1:0]  step_r, step_nxt;

  logic           load, take, has_dec, is_last;
  logic [1:0]     last_step;
  logic [3:0]     mtype;
  mip_pkg::kind_t kind_c;
  logic [13:0]    main_c;
  logic [6:0]     aux_c;
  logic [3:0]     chan_c;

  assign mtype   = head.status[7:4];
  assign has_dec = (mtype == mip_pkg::ST_NOTE_OFF) || (mtype == mip_pkg::ST_NOTE_ON) ||
                   (mtype == mip_pkg::ST_CTRL) || (mtype == mip_pkg::ST_PROG) ||
                   (mtype == mip_pkg::ST_PRES) || (mtype == mip_pkg::ST_BEND);

  // index of the final result of this job
  assign last_step = head.is_rt ? 2'd0 : head.ndata + {1'b0, has_dec};
  assign is_last   = (step_r == last_step);

  assign load = !out_valid_r || out_ch.ready;
  assign take = load && !q_stat.empty;
  assign pop  = take && is_last;

  // result for the current step of the head job
  always_comb begin
    kind_c = mip_pkg::KIND_RAW;
    main_c = {6'b0, head.status};
    aux_c  = '0;
    chan_c = head.status[3:0];
    if (head.is_rt) begin
      kind_c = mip_pkg::KIND_RT;
      chan_c = '0;
    end else if (step_r == 2'd0) begin
      kind_c = mip_pkg::KIND_RAW;
    end else if (step_r <= head.ndata) begin
      main_c = {7'b0, (step_r == 2'd1) ? head.d0 : head.d1};
    end else begin
      case (mtype)
        mip_pkg::ST_NOTE_OFF: begin
          kind_c = mip_pkg::KIND_NOTE;
          main_c = {7'b0, head.d0};
        end
        mip_pkg::ST_NOTE_ON: begin
          kind_c = mip_pkg::KIND_NOTE;
          main_c = {7'b0, head.d0};
          aux_c  = head.d1;
        end
        mip_pkg::ST_CTRL: begin
          kind_c = mip_pkg::KIND_CTRL;
          main_c = {7'b0, head.d1};
          aux_c  = head.d0;
        end
        mip_pkg::ST_PROG: begin
          kind_c = mip_pkg::KIND_PROG;
          main_c = {7'b0, head.d0};
        end
        mip_pkg::ST_PRES: begin
          kind_c = mip_pkg::KIND_PRES;
          main_c = {7'b0, head.d0};
        end
        mip_pkg::ST_BEND: begin
          kind_c = mip_pkg::KIND_BEND;
          main_c = {head.d1, head.d0};
        end
        default: begin
          kind_c = mip_pkg::KIND_RAW;
        end
      endcase
    end
  end

  // step counter within the head job
  always_comb begin
    step_nxt = step_r;
    if (take) begin
      step_nxt = is_last ? 2'd0 : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= !q_stat.empty;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= kind_c;
      main_r <= main_c;
      aux_r  <= aux_c;
      chan_r <= chan_c;
      last_r <= is_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = kind_r;
  assign out_ch.main_value  = main_r;
  assign out_ch.aux_value   = aux_r;
  assign out_ch.channel     = chan_r;
  assign out_ch.last_of_run = last_r;

endmodule

// ----- hdl/midi_input_parser_top.sv -----
// Top level of the MIDI input parser: front end, job queue, back end.
// Depends on mip_pkg, the channel interfaces, mip_front, mip_queue, mip_back.
//
//   channel  dir  payload                                         transfer when
//   in_ch    in   midi_byte[7:0]                                  valid && ready
//   out_ch   out  event_kind, main_value, aux_value, channel,    valid && ready
//                 last_of_run
//   cfg_ch   in   input_enable                                    valid && ready
//
// A byte is classified in the cycle it is taken; ready drops only while the queue is full.
// Results leave one per cycle from the output register while out_ch is ready: 1 for a
// realtime byte, 2 to 4 for a completed message.
// A byte that completes nothing produces no result.
// Reset is synchronous: queue empty, no status, input enabled. cfg_ch is always ready.
// A stall on out_ch holds the back end; the queue lets the front keep taking bytes.
module midi_input_parser_top #(
  parameter int QUEUE_DEPTH = mip_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  midi_in_if.sink    in_ch,
  midi_out_if.source out_ch,
  midi_cfg_if.sink   cfg_ch
);

  logic             push, pop;
  mip_pkg::job_t    push_job, head;
  mip_pkg::q_stat_t q_stat;

  mip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  mip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mip_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hdl/mip_checker.sv -----
// Port-level checker for the MIDI input parser, bound to the top level.
// Depends on mip_pkg and midi_input_parser_top_assert.svh.
`include "midi_input_parser_top_assert.svh"

module mip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [13:0] main_value,
  input logic [6:0]  aux_value,
  input logic [3:0]  channel,
  input logic        last_of_run
);

  // a stalled result holds
  `MIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(main_value) && $stable(event_kind) && $stable(last_of_run), "stalled result changed")

  // nothing is shown right after reset
  `MIP_ASSERT_RST(a_rst_idle, !rst_n, !out_valid, "result valid after reset")

  // the rest of a run follows without a gap
  `MIP_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !last_of_run, out_valid, "gap inside a run")

  // realtime results stand alone with no channel or aux value
  `MIP_ASSERT_NOW(a_rt_single, out_valid && (event_kind == mip_pkg::KIND_RT), last_of_run && (channel == 4'd0) && (aux_value == 7'd0), "bad realtime result")

endmodule

bind midi_input_parser_top mip_checker u_mip_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_kind  (out_ch.event_kind),
  .main_value  (out_ch.main_value),
  .aux_value   (out_ch.aux_value),
  .channel     (out_ch.channel),
  .last_of_run (out_ch.last_of_run)
);

// ----- tb/tb_midi_input_parser_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for midi_input_parser_top: directed and random MIDI byte streams.
// Depends on mip_pkg, the channel interfaces in mip_ifs.sv and the parser RTL.
module tb_midi_input_parser_top;

  localparam int         DRAIN_CYCLES = 16;   // settle time before config writes and at the end
  localparam int         LONG_HOLD    = 300;  // receiver hold-off, long enough to fill the queue
  localparam logic [7:0] RT_FIRST     = 8'hF8;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  // one result as it leaves the block
  typedef struct packed {
    mip_pkg::kind_t kind;
    logic [13:0]    main_value;
    logic [6:0]     aux_value;
    logic [3:0]     chan;
    logic           last;
  } midi_event_t;

  logic clk;
  logic rst_n;

  midi_in_if  in_ch ();
  midi_out_if out_ch ();
  midi_cfg_if cfg_ch ();

  midi_input_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // bytes waiting to be offered, and results the parser owes
  logic [7:0]  tx_bytes [$];
  midi_event_t expected_events [$];
  int          pending_bytes  = 0;
  int          mismatch_count = 0;

  // idling: 0 none, 1 occasional, 2 every item
  int src_mode     = 1;
  int snk_mode     = 1;
  int src_gap      = 0;
  int snk_stall    = 0;
  int hold_trigger = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // parser state as the predictor sees it
  logic       rx_enable;
  logic [7:0] msg_status;
  logic [7:0] run_status;
  logic [6:0] data_hold [0:1];
  logic [1:0] held_count;
  logic [1:0] want_count;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.midi_byte     = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.input_enable = 1'b1;
    rx_enable           = 1'b1;
    msg_status          = NO_STATUS;
    run_status          = NO_STATUS;
    data_hold[0]        = '0;
    data_hold[1]        = '0;
    held_count          = 2'd0;
    want_count          = 2'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int idle_draw(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
    return $urandom_range(0, 18);
  endfunction

  // bytes in a message, status included
  function automatic logic [1:0] bytes_in_message(input logic [7:0] status);
    case (status[7:4])
      mip_pkg::ST_NOTE_OFF, mip_pkg::ST_NOTE_ON, mip_pkg::ST_POLY, mip_pkg::ST_CTRL,
      mip_pkg::ST_BEND:                   return 2'd3;
      mip_pkg::ST_PROG, mip_pkg::ST_PRES: return 2'd2;
      default:                            return 2'd1;
    endcase
  endfunction

  function automatic midi_event_t make_event(input mip_pkg::kind_t k, input logic [13:0] m,
                                             input logic [6:0] a, input logic [3:0] c);
    midi_event_t ev;
    ev.kind       = k;
    ev.main_value = m;
    ev.aux_value  = a;
    ev.chan       = c;
    ev.last       = 1'b0;
    return ev;
  endfunction

  // decode one accepted byte and queue the results it causes
  function automatic void decode_midi_byte(input logic [7:0] b);
    midi_event_t ev [4];
    int          n;
    int          slot;
    logic [3:0]  chan;
    logic [6:0]  d1;
    logic [6:0]  d2;
    n = 0;
    if (rx_enable) begin
      if (b >= RT_FIRST) begin
        ev[0] = make_event(mip_pkg::KIND_RT, {6'd0, b}, 7'd0, 4'd0);
        n     = 1;
      end else if (b[7]) begin
        // a new status drops any partial message
        msg_status = b;
        run_status = b;
        held_count = 2'd1;
        want_count = bytes_in_message(b);
      end else begin
        if (msg_status == NO_STATUS && run_status != NO_STATUS) begin
          msg_status = run_status;
          want_count = bytes_in_message(msg_status);
          held_count = 2'd1;
        end
        // data with no status at all is dropped
        if (msg_status != NO_STATUS) begin
          if (held_count == 2'd0) held_count = 2'd1;
          if (held_count < 2'd3) begin
            slot            = (int'(held_count) - 1) & 1;
            data_hold[slot] = b[6:0];
            held_count      = held_count + 2'd1;
          end
          if (held_count >= want_count) begin
            chan  = msg_status[3:0];
            d1    = (held_count > 2'd1) ? data_hold[0] : 7'd0;
            d2    = (held_count > 2'd2) ? data_hold[1] : 7'd0;
            ev[n] = make_event(mip_pkg::KIND_RAW, {6'd0, msg_status}, 7'd0, chan);
            n++;
            for (int i = 1; i < int'(held_count) && i <= 2; i++) begin
              ev[n] = make_event(mip_pkg::KIND_RAW, {7'd0, data_hold[i-1]}, 7'd0, chan);
              n++;
            end
            // decoded event; poly pressure and system have none
            case (msg_status[7:4])
              mip_pkg::ST_NOTE_OFF: begin
                ev[n] = make_event(mip_pkg::KIND_NOTE, {7'd0, d1}, 7'd0, chan);
                n++;
              end
              mip_pkg::ST_NOTE_ON: begin
                ev[n] = make_event(mip_pkg::KIND_NOTE, {7'd0, d1}, d2, chan);
                n++;
              end
              mip_pkg::ST_CTRL: begin
                ev[n] = make_event(mip_pkg::KIND_CTRL, {7'd0, d2}, d1, chan);
                n++;
              end
              mip_pkg::ST_PROG: begin
                ev[n] = make_event(mip_pkg::KIND_PROG, {7'd0, d1}, 7'd0, chan);
                n++;
              end
              mip_pkg::ST_PRES: begin
                ev[n] = make_event(mip_pkg::KIND_PRES, {7'd0, d1}, 7'd0, chan);
                n++;
              end
              mip_pkg::ST_BEND: begin
                ev[n] = make_event(mip_pkg::KIND_BEND, {d2, d1}, 7'd0, chan);
                n++;
              end
              default: ;
            endcase
            // system clears all status; channel messages keep running status
            if (msg_status[7:4] == mip_pkg::ST_SYSTEM) begin
              msg_status = NO_STATUS;
              run_status = NO_STATUS;
              held_count = 2'd0;
              want_count = 2'd0;
            end else begin
              held_count = 2'd1;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      ev[i].last = (i == n - 1);
      expected_events.push_back(ev[i]);
    end
  endfunction

  // input driver: one transfer per valid && ready edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.midi_byte <= '0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_midi_byte(in_ch.midi_byte);
        pending_bytes--;
        src_gap = idle_draw(src_mode);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          in_ch.valid <= 1'b0;
          src_gap--;
        end else if (tx_bytes.size() != 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.midi_byte <= tx_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) snk_stall = idle_draw(snk_mode);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (snk_stall > 0) begin
        out_ch.ready <= 1'b0;
        snk_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    midi_event_t got;
    midi_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = mip_pkg::kind_t'(out_ch.event_kind);
      got.main_value = out_ch.main_value;
      got.aux_value  = out_ch.aux_value;
      got.chan       = out_ch.channel;
      got.last       = out_ch.last_of_run;
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d main 0x%0h aux 0x%0h ch %0d last %0d",
                   got.kind, got.main_value, got.aux_value, got.chan, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %0d/0x%0h/0x%0h/%0d/%0d got %0d/0x%0h/0x%0h/%0d/%0d",
                     want.kind, want.main_value, want.aux_value, want.chan, want.last,
                     got.kind, got.main_value, got.aux_value, got.chan, got.last);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    pending_bytes++;
  endtask

  // wait until every byte is taken and every result has arrived, then settle
  task automatic wait_drained();
    while (pending_bytes != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_input_enable(input logic value);
    @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.input_enable <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rx_enable = value;
  endtask

  function automatic logic [3:0] pick_voice_type();
    case ($urandom_range(0, 6))
      0:       return mip_pkg::ST_NOTE_OFF;
      1:       return mip_pkg::ST_NOTE_ON;
      2:       return mip_pkg::ST_POLY;
      3:       return mip_pkg::ST_CTRL;
      4:       return mip_pkg::ST_PROG;
      5:       return mip_pkg::ST_PRES;
      default: return mip_pkg::ST_BEND;
    endcase
  endfunction

  // data byte, biased toward the extremes
  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // one random sequence: mostly complete messages, some noise and broken ones
  task automatic add_sequence(input bit voice_only, output int added);
    int         pick;
    int         ndata;
    logic [7:0] st;
    added = 0;
    pick  = voice_only ? 0 : int'($urandom_range(0, 99));
    if (pick < 70) begin
      st    = {pick_voice_type(), 4'($urandom_range(0, 15))};
      ndata = int'(bytes_in_message(st)) - 1;
      push_byte(st);
      added++;
      // extra repeats ride on running status
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < ndata; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_byte(8'($urandom_range(248, 255)));
            added++;
          end
          push_byte(rand_data());
          added++;
        end
      end
    end else if (pick < 78) begin
      // system status, its data byte, and maybe a stray one
      push_byte({mip_pkg::ST_SYSTEM, 4'($urandom_range(0, 7))});
      push_byte(rand_data());
      added += 2;
      if ($urandom_range(0, 1) == 1) begin
        push_byte(rand_data());
        added++;
      end
    end else if (pick < 86) begin
      push_byte(8'($urandom_range(248, 255)));
      added++;
    end else if (pick < 93) begin
      // message cut short; the next status interrupts it
      st = {pick_voice_type(), 4'($urandom_range(0, 15))};
      push_byte(st);
      added++;
      for (int i = 0; i < int'(bytes_in_message(st)) - 2; i++) begin
        push_byte(rand_data());
        added++;
      end
      push_byte({pick_voice_type(), 4'($urandom_range(0, 15))});
      added++;
    end else begin
      push_byte(8'($urandom_range(0, 255)));
      added++;
    end
  endtask

  task automatic fill_random(input int count, input bit voice_only);
    int total;
    int added;
    total = 0;
    while (total < count) begin
      add_sequence(voice_only, added);
      total += added;
    end
  endtask

  // stimulus phases
  initial begin : stimulus
    logic [7:0] directed [] = '{
      8'hF8, 8'h7F,                      // realtime, data with no status
      8'h80, 8'h00, 8'h7F,               // note off, channel 0
      8'h9F, 8'h7F, 8'h00,               // note on, channel 15
      8'h40, 8'hC2, 8'h05,               // running status cut by a program change
      8'hA5, 8'h10, 8'h20,               // poly pressure
      8'hB3, 8'h07, 8'h64,               // control
      8'hD7, 8'h33,                      // channel pressure
      8'hE0, 8'h7F, 8'hFF, 8'h7F,        // full bend with realtime inside
      8'hF3, 8'h01, 8'h02                // system, then data dropped
    };
    @(posedge rst_n);
    write_input_enable(1'b1);

    foreach (directed[i]) push_byte(directed[i]);
    wait_drained();

    // disabled: every byte ignored
    write_input_enable(1'b0);
    for (int i = 0; i < 12; i++) push_byte(8'($urandom_range(0, 255)));
    wait_drained();
    write_input_enable(1'b1);

    src_mode = 0;
    snk_mode = 0;
    fill_random(40, 1'b0);
    wait_drained();

    src_mode = 2;
    snk_mode = 2;
    fill_random(45, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    src_mode = 0;
    snk_mode = 1;
    hold_trigger <= hold_trigger + 1;
    fill_random(50, 1'b1);
    wait_drained();

    write_input_enable(1'b1);
    src_mode = 1;
    snk_mode = 2;
    fill_random(45, 1'b0);
    wait_drained();

    src_mode = 2;
    snk_mode = 0;
    fill_random(40, 1'b0);
    wait_drained();

    if (mismatch_count == 0 && expected_events.size() == 0)
      $display("** midi_input_parser_top: PASSED **");
    else
      $display("** midi_input_parser_top: FAILED **");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("** midi_input_parser_top: FAILED **");
    $finish;
  end

endmodule
